// ===== hw/rtl/skt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subscriber key table package
// Shared command and status codes, beat payload types and the table entry
// layout used by the interfaces, the entry store and the core sequencer.
// ----------------------------------------------------------------------------
package skt_pkg;

   // Most notification beats that one notify command produces.
   localparam int MAX_RESULTS = 16;

   // Request command codes.
   typedef enum logic [2:0] {
      CMD_SUB_FP     = 3'd0,
      CMD_SUB_ID     = 3'd1,
      CMD_UNSUB_FP   = 3'd2,
      CMD_UNSUB_ID   = 3'd3,
      CMD_QUERY_FP   = 3'd4,
      CMD_QUERY_ID   = 3'd5,
      CMD_NOTIFY_ALL = 3'd6,
      CMD_INVALID    = 3'd7
   } skt_cmd_type;

   // Response status codes.
   typedef enum logic [2:0] {
      STAT_OK             = 3'd0,
      STAT_NOT_SUBSCRIBED = 3'd1,
      STAT_TABLE_FULL     = 3'd2,
      STAT_REMOVE_FAILED  = 3'd3,
      STAT_INVALID_CMD    = 3'd4
   } skt_status_type;

   // Request beat payload.
   typedef struct packed {
      skt_cmd_type cmd;
      logic [63:0] fingerprint_high;
      logic [63:0] fingerprint_low;
      logic [15:0] service_id;
      logic [63:0] payload_word;
      logic [15:0] lookup_id;
   } skt_req_type;

   // Response beat payload.
   typedef struct packed {
      skt_status_type status;
      logic [15:0]    issued_id;
      logic           is_notification;
      logic [15:0]    out_service_id;
      logic [63:0]    out_payload;
      logic [31:0]    message_count;
      logic           last;
   } skt_rsp_type;

   // One row of the subscriber table.
   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [15:0] service;
      logic [63:0] payload;
      logic [15:0] issued_id;
   } skt_entry_type;

endpackage

// ===== hw/rtl/skt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subscriber key table channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface skt_req_if;
   import skt_pkg::*;

   logic        valid;
   logic        ready;
   skt_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface skt_rsp_if;
   import skt_pkg::*;

   logic        valid;
   logic        ready;
   skt_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/skt_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subscriber key table entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  skt_pkg::skt_entry_type wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output skt_pkg::skt_entry_type rd_data
);
   import skt_pkg::*;

   skt_entry_type mem_ff [DEPTH];
   skt_entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/skt_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subscriber key table match unit
// Compares one table entry against the fingerprint or the lookup id.
// ----------------------------------------------------------------------------
module skt_cmp (
   input  skt_pkg::skt_entry_type entry,
   input  logic [63:0]            key_high,
   input  logic [63:0]            key_low,
   input  logic [15:0]            lookup_id,
   input  logic                   by_id,
   output logic                   match
);
   import skt_pkg::*;

   logic key_hit;
   logic id_hit;

   // Full 128-bit fingerprint compare and 16-bit id compare.
   assign key_hit = (entry.key_high == key_high) && (entry.key_low == key_low);
   assign id_hit  = (entry.issued_id == lookup_id);
   assign match   = by_id ? id_hit : key_hit;

endmodule

// ===== hw/rtl/subscriber_key_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subscriber key table core
// Keeps up to TABLE_ENTRIES subscribers packed in slots 0..count-1 and walks
// them with one shared read port and one match unit under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake    | Beat contents
//  req_ch   | in        | valid/ready  | cmd, fingerprint, service, payload, id
//  rsp_ch   | out       | valid/ready  | status, issued id, notify fields, last
//
// A lookup walks the table one entry per cycle through the read port, then
// acts on the result in S_EXEC and posts the response beat in S_RESP.
// A remove shifts the later entries down, one entry per cycle on the same port.
// A notify reads each entry in S_NT_RD and emits its beat in S_NT_OUT.
// Reset clears the entry count, the id counter (to one) and the message count.
// A stalled response holds its register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module subscriber_key_table_core #(
   parameter int TABLE_ENTRIES = 16
) (
   input logic     clock,
   input logic     reset,
   skt_req_if.sink   req_ch,
   skt_rsp_if.source rsp_ch
);
   import skt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC,
      S_SHIFT,
      S_RESP,
      S_NT_RD,
      S_NT_OUT
   } state_type;

   state_type     state_ff, state_in;
   skt_req_type   req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]   next_id_ff, next_id_in;
   logic [31:0]   msg_cnt_ff, msg_cnt_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic          found_ff, found_in;
   logic [CNT_W-1:0] hit_idx_ff, hit_idx_in;
   skt_rsp_type   res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   skt_rsp_type   rsp_ff, rsp_in;

   logic          rd_en;
   logic [IDX_W-1:0] rd_addr;
   skt_entry_type rd_data;
   logic          wr_en;
   logic [IDX_W-1:0] wr_addr;
   skt_entry_type wr_data;
   logic          by_id;
   logic          match;
   logic          rsp_free;
   logic          req_fire;
   logic          table_full;
   logic          nt_last;

   // Single-beat response with the given status and id.
   function automatic skt_rsp_type single_rsp(skt_status_type st, logic [15:0] id);
      skt_rsp_type r;
      r.status          = st;
      r.issued_id       = id;
      r.is_notification = 1'b0;
      r.out_service_id  = 16'd0;
      r.out_payload     = 64'd0;
      r.message_count   = 32'd0;
      r.last            = 1'b1;
      return r;
   endfunction

   skt_store #(
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   skt_cmp u_cmp (
      .entry     (rd_data),
      .key_high  (req_ff.fingerprint_high),
      .key_low   (req_ff.fingerprint_low),
      .lookup_id (req_ff.lookup_id),
      .by_id     (by_id),
      .match     (match)
   );

   // Handshake helpers.
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == S_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign by_id = (req_ff.cmd == CMD_UNSUB_ID) || (req_ff.cmd == CMD_QUERY_ID);
   assign table_full = (32'(count_ff) == 32'(TABLE_ENTRIES));
   assign nt_last = (32'(ptr_ff) + 32'd1 == 32'(count_ff)) ||
                    (32'(ptr_ff) + 32'd1 == 32'(MAX_RESULTS));

   // Sequencer next-state and datapath control.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      next_id_in   = next_id_ff;
      msg_cnt_in   = msg_cnt_ff;
      ptr_in       = ptr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff[IDX_W-1:0];
      wr_data      = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in   = req_ch.payload;
               ptr_in   = '0;
               found_in = 1'b0;
               case (req_ch.payload.cmd)
                  CMD_NOTIFY_ALL: begin
                     // An empty table produces no beat at all.
                     if (count_ff != '0) begin
                        state_in = S_NT_RD;
                     end
                  end
                  CMD_INVALID: begin
                     res_in   = single_rsp(STAT_INVALID_CMD, 16'd0);
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = (count_ff == '0) ? S_EXEC : S_SCAN;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Issue one read per cycle and check the entry read last cycle.
            if (ptr_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = ptr_ff;
               ptr_in    = ptr_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (match) begin
                  found_in   = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  rd_vld_in  = 1'b0;
                  state_in   = S_EXEC;
               end else if (rd_idx_ff + CNT_W'(1) == count_ff) begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            state_in = S_RESP;
            case (req_ff.cmd)
               CMD_SUB_FP, CMD_SUB_ID: begin
                  wr_data.key_high  = req_ff.fingerprint_high;
                  wr_data.key_low   = req_ff.fingerprint_low;
                  wr_data.service   = req_ff.service_id;
                  wr_data.payload   = req_ff.payload_word;
                  wr_data.issued_id = next_id_ff;
                  if (found_ff) begin
                     wr_en = 1'b1;
                  end else if (!table_full) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                  end
                  if (found_ff || !table_full) begin
                     next_id_in = next_id_ff + 16'd1;
                     res_in = single_rsp(STAT_OK,
                        (req_ff.cmd == CMD_SUB_ID) ? next_id_ff : 16'd0);
                  end else begin
                     res_in = single_rsp(STAT_TABLE_FULL, 16'd0);
                  end
               end
               CMD_UNSUB_FP, CMD_UNSUB_ID: begin
                  if (found_ff) begin
                     res_in   = single_rsp(STAT_OK, 16'd0);
                     ptr_in   = hit_idx_ff + CNT_W'(1);
                     state_in = S_SHIFT;
                  end else begin
                     res_in = single_rsp(STAT_REMOVE_FAILED, 16'd0);
                  end
               end
               CMD_QUERY_FP, CMD_QUERY_ID: begin
                  res_in = single_rsp(found_ff ? STAT_OK : STAT_NOT_SUBSCRIBED, 16'd0);
               end
               default: begin
                  res_in = single_rsp(STAT_INVALID_CMD, 16'd0);
               end
            endcase
         end

         S_SHIFT: begin
            // Read entry i+1 while entry i's data lands one slot lower.
            if (ptr_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = ptr_ff;
               ptr_in    = ptr_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(rd_idx_ff - CNT_W'(1));
               wr_data = rd_data;
            end
            if (ptr_ff == count_ff && !rd_vld_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_NT_RD: begin
            rd_en    = 1'b1;
            state_in = S_NT_OUT;
         end

         S_NT_OUT: begin
            if (rsp_free) begin
               msg_cnt_in             = msg_cnt_ff + 32'd1;
               rsp_in.status          = STAT_OK;
               rsp_in.issued_id       = 16'd0;
               rsp_in.is_notification = 1'b1;
               rsp_in.out_service_id  = rd_data.service;
               rsp_in.out_payload     = rd_data.payload;
               rsp_in.message_count   = msg_cnt_ff + 32'd1;
               rsp_in.last            = nt_last;
               rsp_valid_in           = 1'b1;
               if (nt_last) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + CNT_W'(1);
                  state_in = S_NT_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_id_ff   <= 16'd1;
         msg_cnt_ff   <= 32'd0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         msg_cnt_ff   <= msg_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      ptr_ff     <= ptr_in;
      rd_idx_ff  <= rd_idx_in;
      hit_idx_ff <= hit_idx_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // The table never holds more entries than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(TABLE_ENTRIES))
      else $error("entry count exceeds table size");

   // Writes only land inside the packed region or at its append slot.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> 32'(wr_addr) <= 32'(count_ff))
      else $error("table write beyond the packed entries");

   // A subscribe rejected for a full table does not consume an id.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && !found_ff && table_full &&
       (req_ff.cmd == CMD_SUB_FP || req_ff.cmd == CMD_SUB_ID))
      |=> $stable(next_id_ff))
      else $error("id advanced on a full-table subscribe");

endmodule
